[design/ece_pkg.sv]
package ece_pkg;

   // Curve selector codes.
   localparam logic [2:0] OP_LINEAR      = 3'd0;
   localparam logic [2:0] OP_OVERSHOOT   = 3'd1;
   localparam logic [2:0] OP_OUT_BACK    = 3'd2;
   localparam logic [2:0] OP_OUT_QUART   = 3'd3;
   localparam logic [2:0] OP_BOUNCE      = 3'd4;
   localparam logic [2:0] OP_BOUNCE_HOLD = 3'd5;
   localparam logic [2:0] OP_STEP        = 3'd6;

   // Fixed-point units.
   localparam int ECE_ONE_Q15  = 32767;
   localparam int ECE_Q14_ONE  = 16384;
   localparam int ECE_Q15_FULL = 32768;

   // Overshoot curve: peak and the point where the rise turns into the settle.
   localparam int ECE_OS_PEAK  = 18841;
   localparam int ECE_OS_SPLIT = 11468;

   // The rise and settle divisions reduce to n * 4096 / 2867 and n * 4096 / 1229.
   // Both are done with a rounded-up reciprocal that is exact over the operand range.
   localparam int ECE_OS_NUM_SH    = 12;
   localparam int ECE_OS_RISE_DIV  = ECE_OS_SPLIT / 4;
   localparam int ECE_OS_FALL_DIV  = (ECE_Q14_ONE - ECE_OS_SPLIT) / 4;
   localparam int ECE_OS_RISE_SH   = 38;
   localparam int ECE_OS_FALL_SH   = 36;
   localparam longint ECE_OS_RECIP_RISE =
      ((longint'(1) << ECE_OS_RISE_SH) + ECE_OS_RISE_DIV - 1) / ECE_OS_RISE_DIV;
   localparam longint ECE_OS_RECIP_FALL =
      ((longint'(1) << ECE_OS_FALL_SH) + ECE_OS_FALL_DIV - 1) / ECE_OS_FALL_DIV;
   localparam int ECE_OS_RECIP_W = 27;
   localparam int ECE_OS_T_W     = 14;

   // Out-back coefficients.
   localparam int ECE_OB_SQUARE = 55754;
   localparam int ECE_OB_CUBE   = 88521;

   // Bounce segments: upper edges, centers and bases.
   localparam int ECE_BOUNCE_K = 247868;
   localparam int ECE_BNC_EDGE1 = 11911;
   localparam int ECE_BNC_EDGE2 = 23822;
   localparam int ECE_BNC_EDGE3 = 29778;
   localparam int ECE_BNC_MID2  = 18181;
   localparam int ECE_BNC_MID3  = 27272;
   localparam int ECE_BNC_MID4  = 31111;
   localparam int ECE_BNC_BASE2 = 24576;
   localparam int ECE_BNC_BASE3 = 29490;
   localparam int ECE_BNC_BASE4 = 31539;

   // Staircase step count.
   localparam int ECE_STEPS = 10;

   // Divider quotient width, one bit per stage.
   localparam int ECE_QUOT_W = 16;

   // Default depth of the queue between front and back.
   localparam int ECE_QUEUE_DEPTH = 4;

   // Side data that travels with a word through the back end.
   typedef struct packed {
      logic [2:0]  op;
      logic        bypass;
      logic [15:0] bypass_value;
      logic [15:0] from_value;
      logic [15:0] to_value;
   } ece_ctx_type;

   // One classified word as it sits in the queue.
   typedef struct packed {
      ece_ctx_type ctx;
      logic [2*ECE_QUOT_W-1:0] dividend;
      logic [ECE_QUOT_W-1:0]   divisor;
   } ece_item_type;

   // Staircase progress: idx * 32768 / 10, truncated.
   function automatic logic [14:0] step_progress(input logic [3:0] idx);
      logic [14:0] p;
      case (idx)
         4'd1:    p = 15'd3276;
         4'd2:    p = 15'd6553;
         4'd3:    p = 15'd9830;
         4'd4:    p = 15'd13107;
         4'd5:    p = 15'd16384;
         4'd6:    p = 15'd19660;
         4'd7:    p = 15'd22937;
         4'd8:    p = 15'd26214;
         4'd9:    p = 15'd29491;
         default: p = 15'd0;
      endcase
      return p;
   endfunction

   // Sign extension of a 16-bit value to 32 bits.
   function automatic logic [31:0] sext32(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

[design/ece_front.sv]
module ece_front (
   input  logic               start,
   input  logic               queue_full,
   input  logic [2:0]         op,
   input  logic [15:0]        elapsed,
   input  logic [15:0]        span,
   input  logic [15:0]        from_value,
   input  logic [15:0]        to_value,
   output logic               busy,
   output logic               push,
   output ece_pkg::ece_item_type item
);
   import ece_pkg::*;

   logic [15:0] half;
   logic        finished;
   logic        at_start;
   logic        hold_done;

   // The front holds off new words only while the queue is full.
   assign busy = queue_full;
   assign push = start && !queue_full;

   // Classify the end cases that need no arithmetic.
   assign half      = span >> 1;
   assign finished  = (elapsed >= span) || (op > OP_STEP);
   assign at_start  = (elapsed == 16'd0);
   assign hold_done = (op == OP_BOUNCE_HOLD) && (elapsed >= half);

   always_comb begin
      item.ctx.op           = op;
      item.ctx.from_value   = from_value;
      item.ctx.to_value     = to_value;
      item.ctx.bypass       = finished || at_start || hold_done;
      item.ctx.bypass_value = (!finished && at_start) ? from_value : to_value;
      item.divisor          = (op == OP_BOUNCE_HOLD) ? half : span;

      // Progress numerator in the curve's own scale.
      unique case (op) inside
         OP_LINEAR:    item.dividend = {elapsed, 16'd0};
         OP_OVERSHOOT: item.dividend = {2'd0, elapsed, 14'd0};
         OP_OUT_BACK, OP_OUT_QUART, OP_BOUNCE, OP_BOUNCE_HOLD:
            item.dividend = {1'b0, elapsed, 15'd0};
         OP_STEP:      item.dividend = 32'(20'(elapsed) * 20'(ECE_STEPS));
         default:      item.dividend = 32'd0;
      endcase
   end

endmodule

[design/ece_queue.sv]
module ece_queue #(
   parameter int DEPTH = ece_pkg::ECE_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ece_pkg::ece_item_type push_item,
   output logic                  full,
   output logic                  pop_valid,
   output ece_pkg::ece_item_type pop_item
);
   import ece_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ece_item_type mem_ff [DEPTH];
   ece_item_type pop_item_ff;
   logic          pop_valid_ff;
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   // The back end never stalls, so a stored word leaves on the next cycle.
   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Pointers, fill count and output strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         pop_valid_ff <= do_pop;
      end
   end

   // Storage and registered read.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
      if (do_pop) begin
         pop_item_ff <= mem_ff[rd_ptr_ff];
      end
   end

   assign pop_valid = pop_valid_ff;
   assign pop_item  = pop_item_ff;

endmodule

[design/ece_div.sv]
module ece_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  ece_pkg::ece_item_type in_item,
   output logic                  out_valid,
   output ece_pkg::ece_ctx_type  out_ctx,
   output logic [ece_pkg::ECE_QUOT_W-1:0] out_quot
);
   import ece_pkg::*;

   localparam int STEPS = ECE_QUOT_W;
   localparam int WW    = 2 * STEPS;

   logic [STEPS:0]    v_ff;
   logic [WW-1:0]     w_ff [STEPS+1];
   logic [STEPS-1:0]  d_ff [STEPS+1];
   ece_ctx_type       c_ff [STEPS+1];
   logic [WW-1:0]     w_in [STEPS];
   logic [WW:0]       sh   [STEPS];
   logic [STEPS:0]    diff [STEPS];

   // One restoring step per stage: shift the partial remainder and try to subtract.
   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         sh[i]   = {w_ff[i], 1'b0};
         diff[i] = sh[i][WW:STEPS] - {1'b0, d_ff[i]};
         if (sh[i][WW:STEPS] >= {1'b0, d_ff[i]}) begin
            w_in[i] = {diff[i][STEPS-1:0], sh[i][STEPS-1:1], 1'b1};
         end else begin
            w_in[i] = sh[i][WW-1:0];
         end
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STEPS-1:0], in_valid};
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      w_ff[0] <= in_item.dividend;
      d_ff[0] <= in_item.divisor;
      c_ff[0] <= in_item.ctx;
      for (int i = 0; i < STEPS; i++) begin
         w_ff[i+1] <= w_in[i];
         d_ff[i+1] <= d_ff[i];
         c_ff[i+1] <= c_ff[i];
      end
   end

   assign out_valid = v_ff[STEPS];
   assign out_ctx   = c_ff[STEPS];
   assign out_quot  = w_ff[STEPS][STEPS-1:0];

endmodule

[design/ece_curve.sv]
module ece_curve (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ece_pkg::ece_ctx_type in_ctx,
   input  logic [ece_pkg::ECE_QUOT_W-1:0] in_quot,
   output logic                 rsp_valid,
   output logic [31:0]          rsp_value
);
   import ece_pkg::*;

   logic [4:0] v_ff;

   ece_ctx_type ctx_a_ff, ctx_b_ff, ctx_c_ff, ctx_d_ff;
   logic signed [19:0] xa_ff, ya_ff, xa_in, ya_in;
   logic signed [19:0] xb_ff, xb_in, xc_ff, xc_in;
   logic               low_a_ff, low_b_ff;
   logic signed [36:0] dp_ff, dp_in;
   logic [31:0]        value_ff, value_in;

   // Stage A signals.
   logic [15:0]         q;
   logic                os_low;
   logic [15:0]         os_u;
   logic [25:0]         os_num;
   logic [ECE_OS_RECIP_W-1:0] os_recip;
   logic [52:0]         os_prod;
   logic [ECE_OS_T_W-1:0] os_t;
   logic signed [16:0]  ob_m;
   logic signed [33:0]  ob_sq;
   logic signed [35:0]  ob_cube;
   logic [15:0]         qt_inv;
   logic [31:0]         qt_sq;
   logic signed [16:0]  bn_d;
   logic signed [19:0]  bn_base;
   logic signed [33:0]  bn_sq;

   // Stage B, C, D, E signals.
   logic signed [19:0]  mb_a, mb_b;
   logic signed [39:0]  mb_prod;
   logic signed [19:0]  mc_b;
   logic signed [39:0]  mc_prod;
   logic signed [16:0]  delta;
   logic signed [36:0]  dp_sh;

   assign q = in_quot;

   // Stage A: first products from the progress value.
   always_comb begin
      // Overshoot rise or settle, scaled by a reciprocal.
      os_low   = (q < 16'(ECE_OS_SPLIT));
      os_u     = os_low ? q : q - 16'(ECE_OS_SPLIT);
      os_num   = {os_u[ECE_OS_T_W-1:0], ECE_OS_NUM_SH'(0)};
      os_recip = os_low ? ECE_OS_RECIP_W'(ECE_OS_RECIP_RISE)
                        : ECE_OS_RECIP_W'(ECE_OS_RECIP_FALL);
      os_prod  = 53'(os_num) * 53'(os_recip);
      os_t     = os_low ? os_prod[ECE_OS_RISE_SH +: ECE_OS_T_W]
                        : os_prod[ECE_OS_FALL_SH +: ECE_OS_T_W];

      // Out-back terms around t minus one.
      ob_m    = $signed({1'b0, q}) - 17'(ECE_ONE_Q15);
      ob_sq   = ob_m * ob_m;
      ob_cube = ob_m * 19'(ECE_OB_CUBE);

      // Out-quartic square.
      qt_inv = 16'(ECE_ONE_Q15) - q;
      qt_sq  = qt_inv * qt_inv;

      // Bounce segment selection.
      if (q < 16'(ECE_BNC_EDGE1)) begin
         bn_d    = $signed({1'b0, q});
         bn_base = '0;
      end else if (q < 16'(ECE_BNC_EDGE2)) begin
         bn_d    = $signed({1'b0, q}) - 17'(ECE_BNC_MID2);
         bn_base = 20'(ECE_BNC_BASE2);
      end else if (q < 16'(ECE_BNC_EDGE3)) begin
         bn_d    = $signed({1'b0, q}) - 17'(ECE_BNC_MID3);
         bn_base = 20'(ECE_BNC_BASE3);
      end else begin
         bn_d    = $signed({1'b0, q}) - 17'(ECE_BNC_MID4);
         bn_base = 20'(ECE_BNC_BASE4);
      end
      bn_sq = bn_d * bn_d;

      xa_in = '0;
      ya_in = '0;
      case (in_ctx.op) inside
         OP_LINEAR:    xa_in = 20'(q);
         OP_OVERSHOOT: xa_in = 20'(os_t);
         OP_OUT_BACK: begin
            xa_in = 20'(ob_sq >>> 15);
            ya_in = 20'((ob_cube >>> 15) + 36'(ECE_OB_SQUARE));
         end
         OP_OUT_QUART: xa_in = 20'(qt_sq >> 15);
         OP_BOUNCE, OP_BOUNCE_HOLD: begin
            xa_in = 20'(bn_sq >>> 15);
            ya_in = bn_base;
         end
         OP_STEP:      xa_in = 20'(step_progress(q[3:0]));
         default:      xa_in = '0;
      endcase
   end

   // Stage B: one shared multiplier, operands picked by curve.
   always_comb begin
      case (ctx_a_ff.op) inside
         OP_OVERSHOOT: begin
            if (low_a_ff) begin
               mb_a = xa_ff;
               mb_b = 20'(ECE_Q15_FULL) - xa_ff;
            end else begin
               mb_a = 20'(ECE_Q14_ONE) - xa_ff;
               mb_b = 20'(ECE_Q14_ONE) - xa_ff;
            end
         end
         OP_OUT_BACK: begin
            mb_a = xa_ff;
            mb_b = ya_ff;
         end
         OP_OUT_QUART: begin
            mb_a = xa_ff;
            mb_b = xa_ff;
         end
         OP_BOUNCE, OP_BOUNCE_HOLD: begin
            mb_a = xa_ff;
            mb_b = 20'(ECE_BOUNCE_K);
         end
         default: begin
            mb_a = xa_ff;
            mb_b = '0;
         end
      endcase
      mb_prod = mb_a * mb_b;

      case (ctx_a_ff.op) inside
         OP_OVERSHOOT: xb_in = 20'(mb_prod >>> 14);
         OP_OUT_BACK:  xb_in = 20'((mb_prod >>> 15) + 40'(ECE_ONE_Q15));
         OP_OUT_QUART: xb_in = 20'(40'(ECE_ONE_Q15) - (mb_prod >>> 15));
         OP_BOUNCE, OP_BOUNCE_HOLD: xb_in = 20'((mb_prod >>> 15) + 40'(ya_ff));
         default:      xb_in = xa_ff;
      endcase
   end

   // Stage C: overshoot scaling to its peak, or the settle from one to the peak; other curves pass through.
   always_comb begin
      mc_b    = low_b_ff ? 20'(ECE_OS_PEAK) : 20'(ECE_OS_PEAK - ECE_Q14_ONE);
      mc_prod = xb_ff * mc_b;
      if (ctx_b_ff.op == OP_OVERSHOOT) begin
         if (low_b_ff) begin
            xc_in = 20'(mc_prod >>> 14);
         end else begin
            xc_in = 20'((mc_prod >>> 14) + 40'(ECE_Q14_ONE));
         end
      end else begin
         xc_in = xb_ff;
      end
   end

   // Stage D: scale the span between the end values by the progress.
   assign delta = $signed({ctx_c_ff.to_value[15], ctx_c_ff.to_value})
                - $signed({ctx_c_ff.from_value[15], ctx_c_ff.from_value});
   assign dp_in = delta * xc_ff;

   // Stage E: drop the fraction and add the start value, or take the bypass value.
   always_comb begin
      case (ctx_d_ff.op) inside
         OP_LINEAR:    dp_sh = dp_ff >>> 16;
         OP_OVERSHOOT: dp_sh = dp_ff >>> 14;
         default:      dp_sh = dp_ff >>> 15;
      endcase
      if (ctx_d_ff.bypass) begin
         value_in = sext32(ctx_d_ff.bypass_value);
      end else begin
         value_in = sext32(ctx_d_ff.from_value) + 32'(dp_sh);
      end
   end

   // Stage valids.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      ctx_a_ff <= in_ctx;
      xa_ff    <= xa_in;
      ya_ff    <= ya_in;
      low_a_ff <= os_low;
      ctx_b_ff <= ctx_a_ff;
      xb_ff    <= xb_in;
      low_b_ff <= low_a_ff;
      ctx_c_ff <= ctx_b_ff;
      xc_ff    <= xc_in;
      ctx_d_ff <= ctx_c_ff;
      dp_ff    <= dp_in;
      value_ff <= value_in;
   end

   assign rsp_valid = v_ff[4];
   assign rsp_value = value_ff;

endmodule

[design/easing_curve_evaluator.sv]
// Channel   Ports                                        Handshake
// request   req_op req_elapsed req_span                  start high, busy low
//           req_from_value req_to_value
// response  rsp_value                                    rsp_valid, one cycle
//
// One word can be taken every clock cycle while busy is low. Between the edge that takes it
// and its result lie the queue write and its registered read, the divider input register and
// its 16 quotient stages, and the five curve stages. Synchronous reset clears the queue and
// all stage valids; no result is in flight after it. The receiver cannot stall, so the back
// end drains the queue every cycle and busy stays low for a queue depth of two or more.
module easing_curve_evaluator #(
   parameter int QUEUE_DEPTH = ece_pkg::ECE_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_elapsed,
   input  logic [15:0] req_span,
   input  logic [15:0] req_from_value,
   input  logic [15:0] req_to_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_value
);
   import ece_pkg::*;

   ece_item_type          push_item;
   ece_item_type          pop_item;
   logic                  push;
   logic                  queue_full;
   logic                  pop_valid;
   logic                  div_valid;
   ece_ctx_type           div_ctx;
   logic [ECE_QUOT_W-1:0] div_quot;

   // Front: take and classify words.
   ece_front u_front (
      .start      (start),
      .queue_full (queue_full),
      .op         (req_op),
      .elapsed    (req_elapsed),
      .span       (req_span),
      .from_value (req_from_value),
      .to_value   (req_to_value),
      .busy       (busy),
      .push       (push),
      .item       (push_item)
   );

   // Queue between front and back.
   ece_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_item  (pop_item)
   );

   // Back: progress division.
   ece_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_item   (pop_item),
      .out_valid (div_valid),
      .out_ctx   (div_ctx),
      .out_quot  (div_quot)
   );

   // Back: curve shaping and interpolation.
   ece_curve u_curve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_ctx    (div_ctx),
      .in_quot   (div_quot),
      .rsp_valid (rsp_valid),
      .rsp_value (rsp_value)
   );

endmodule

[design/ece_checker.sv]
module ece_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_op,
   input logic [15:0] req_elapsed,
   input logic [15:0] req_span,
   input logic [15:0] req_from_value,
   input logic [15:0] req_to_value,
   input logic        rsp_valid,
   input logic [31:0] rsp_value
);

   // The queue always drains, so with a depth of two or more the block never pushes back.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although the back end never stalls");

   // Every result belongs to a word taken a fixed latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 24))
      else $error("result without a matching request");

   // Every taken word gives a result after the fixed latency.
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##24 rsp_valid)
      else $error("request produced no result");

   // A finished animation returns the end value.
   a_finished: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_elapsed >= req_span)) |-> ##24
      (rsp_value == {{16{$past(req_to_value[15], 24)}}, $past(req_to_value, 24)}))
      else $error("finished animation did not return the end value");

endmodule

bind easing_curve_evaluator ece_checker u_ece_checker (.*);

[bench/easing_curve_evaluator_tb.sv]
module easing_curve_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ece_pkg::*;

   localparam int LATENCY     = 24;
   localparam int STALL_LIMIT = 2000;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [15:0] req_elapsed = '0;
   logic [15:0] req_span = '0;
   logic [15:0] req_from_value = '0;
   logic [15:0] req_to_value = '0;
   logic        rsp_valid;
   logic [31:0] rsp_value;

   logic [31:0] expected_values[$];
   int          error_count = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          idle_cycles = 0;
   bit          no_gaps = 1'b0;

   easing_curve_evaluator u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_elapsed    (req_elapsed),
      .req_span       (req_span),
      .req_from_value (req_from_value),
      .req_to_value   (req_to_value),
      .rsp_valid      (rsp_valid),
      .rsp_value      (rsp_value)
   );

   always #4 clock = ~clock;

   // Floor shift of a signed value.
   function automatic longint floor_shift(input longint x, input int s);
      return x >>> s;
   endfunction

   // Bounce progress in Q15 for a Q15 time.
   function automatic longint bounce_q15(input longint t);
      longint d, base;
      if (t < ECE_BNC_EDGE1) begin
         d = t;
         base = 0;
      end else if (t < ECE_BNC_EDGE2) begin
         d = t - ECE_BNC_MID2;
         base = ECE_BNC_BASE2;
      end else if (t < ECE_BNC_EDGE3) begin
         d = t - ECE_BNC_MID3;
         base = ECE_BNC_BASE3;
      end else begin
         d = t - ECE_BNC_MID4;
         base = ECE_BNC_BASE4;
      end
      return ((longint'(ECE_BOUNCE_K) * ((d * d) >>> 15)) >>> 15) + base;
   endfunction

   // Curve value for one request word.
   function automatic logic [31:0] eased_value(input logic [2:0] op, input logic [15:0] el,
                                               input logic [15:0] sp, input logic [15:0] fv,
                                               input logic [15:0] tv);
      longint e, span, from, to, delta, t, p, m, sq, inner, inv, inv2, half, t1, t2, eb;
      int     shift_amt;
      e = el;
      span = sp;
      from = longint'(signed'(fv));
      to = longint'(signed'(tv));
      delta = to - from;
      shift_amt = 15;
      if (e >= span || op == OP_UNUSED) return to[31:0];
      if (e == 0) return from[31:0];
      case (op)
         OP_LINEAR: begin
            p = (e <<< 16) / span;
            shift_amt = 16;
         end
         OP_OVERSHOOT: begin
            t = (e * 16384) / span;
            if (t < ECE_OS_SPLIT) begin
               t1 = (t * 16384) / ECE_OS_SPLIT;
               p = (t1 * (32768 - t1)) >>> 14;
               p = (p * ECE_OS_PEAK) >>> 14;
            end else begin
               t2 = ((t - ECE_OS_SPLIT) * 16384) / (16384 - ECE_OS_SPLIT);
               inv = 16384 - t2;
               eb = (inv * inv) >>> 14;
               p = 16384 + ((eb * (ECE_OS_PEAK - 16384)) >>> 14);
            end
            shift_amt = 14;
         end
         OP_OUT_BACK: begin
            t = (e <<< 15) / span;
            m = t - ECE_ONE_Q15;
            sq = (m * m) >>> 15;
            inner = floor_shift(longint'(ECE_OB_CUBE) * m, 15) + ECE_OB_SQUARE;
            p = floor_shift(sq * inner, 15) + ECE_ONE_Q15;
         end
         OP_OUT_QUART: begin
            t = (e <<< 15) / span;
            inv = ECE_ONE_Q15 - t;
            inv2 = (inv * inv) >>> 15;
            p = ECE_ONE_Q15 - ((inv2 * inv2) >>> 15);
         end
         OP_BOUNCE: begin
            p = bounce_q15((e <<< 15) / span);
         end
         OP_BOUNCE_HOLD: begin
            half = span / 2;
            if (e >= half || half == 0) return to[31:0];
            p = bounce_q15((e <<< 15) / half);
         end
         default: begin
            p = (((e * ECE_STEPS) / span) <<< 15) / ECE_STEPS;
         end
      endcase
      return 32'(from + floor_shift(delta * p, shift_amt));
   endfunction

   // Send one word; the expected value is queued at the edge where start meets busy low.
   task automatic send_word(input logic [2:0] op, input logic [15:0] el, input logic [15:0] sp,
                            input logic [15:0] fv, input logic [15:0] tv);
      while (!no_gaps && $urandom_range(99) < 11) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_elapsed <= el;
      req_span <= sp;
      req_from_value <= fv;
      req_to_value <= tv;
      // Busy only changes at a rising edge, so its value here holds until the next one.
      #0;
      while (busy) @(negedge clock);
      @(posedge clock);
      expected_values.push_back(eased_value(op, el, sp, fv, tv));
      words_sent++;
      @(negedge clock);
   endtask

   task automatic go_quiet();
      start <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      go_quiet();
      while (expected_values.size() != 0) @(negedge clock);
   endtask

   // Field extremes, every curve and the named corner cases.
   task automatic test_directed();
      logic [2:0] op;
      for (int k = 0; k <= 7; k++) begin
         op = 3'(k);
         send_word(op, 16'd0, 16'd0, 16'h8000, 16'h7fff);
         send_word(op, 16'd1000, 16'd1000, 16'h8000, 16'h7fff);
         send_word(op, 16'd0, 16'd65535, 16'h7fff, 16'h8000);
         send_word(op, 16'd65534, 16'd65535, 16'h8000, 16'h7fff);
         send_word(op, 16'd1, 16'd65535, 16'hffff, 16'h0000);
         send_word(op, 16'd300, 16'd1000, 16'h7fff, 16'h8000);
      end
      // Bounce with hold around half the span, and a span whose half is zero.
      send_word(OP_BOUNCE_HOLD, 16'd499, 16'd1000, 16'h0000, 16'h7fff);
      send_word(OP_BOUNCE_HOLD, 16'd500, 16'd1000, 16'h0000, 16'h7fff);
      send_word(OP_BOUNCE_HOLD, 16'd0, 16'd1, 16'h1234, 16'h4321);
   endtask

   // Random words; most land inside the span so the curves are exercised.
   task automatic test_random(input int count);
      logic [15:0] sp, el;
      for (int i = 0; i < count; i++) begin
         no_gaps = (i >= count / 3 && i < count / 3 + 200);
         if ($urandom_range(3) == 0) sp = 16'($urandom_range(1, 40));
         else sp = 16'($urandom);
         if ($urandom_range(9) == 0) el = 16'($urandom);
         else if (sp == 0) el = 16'd0;
         else el = 16'($urandom_range(0, sp - 1));
         send_word(3'($urandom_range(7)), el, sp, 16'($urandom), 16'($urandom));
         // Pause the sender once until the pipeline is empty.
         if (i == count / 2) drain();
      end
      no_gaps = 1'b0;
   endtask

   // Compare each result with the oldest expected word.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_values.size() == 0) begin
            $error("unexpected result: value actual %0d", $signed(rsp_value));
            error_count++;
         end else begin
            logic [31:0] want;
            want = expected_values.pop_front();
            words_checked++;
            if (rsp_value !== want) begin
               $error("value mismatch: expected %0d actual %0d", $signed(want),
                      $signed(rsp_value));
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word or result.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random(1520);
      drain();
      repeat (LATENCY + 4) @(negedge clock);
      if (expected_values.size() != 0) begin
         $error("%0d results never arrived", expected_values.size());
         error_count++;
      end
      $display("Covered %0d words over all curve selectors, span and elapsed extremes,",
               words_sent);
      $display("and %0d results checked with random gaps on the request side.", words_checked);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
